### rtl/outstanding_ping_tracker_unit_macros.svh
// Assertion macros used by the ping tracker RTL
`ifndef OUTSTANDING_PING_TRACKER_UNIT_MACROS_SVH
`define OUTSTANDING_PING_TRACKER_UNIT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define OPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ping tracker assertion failed");

// clocked assertion that also holds during reset
`define OPT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ping tracker assertion failed");

`endif

### rtl/opt_pkg.sv
// Types and constants of the outstanding ping tracker
package opt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [31:0] BCAST_ADDR = 32'hFFFF_FFFF;
    localparam logic [13:0] RTT_NONE   = 14'd9999;
    localparam logic [31:0] RTT_NONE_W = 32'd9999;
    localparam logic [7:0]  CAUSE_NONE = 8'd255;
    localparam logic [7:0]  CMD_STATUS = 8'd3;
    localparam logic [7:0]  CMD_BASIC  = 8'd0;

    localparam logic [15:0] TIMEOUT_RST = 16'd1500;
    localparam logic [1:0]  RETRIES_RST = 2'd1;
    localparam logic [7:0]  AUTO_RST    = 8'd0;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_RETRIES = 2'd1,
        CFG_AUTO    = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_PING   = 2'd0,
        OP_REPLY  = 2'd1,
        OP_TICK   = 2'd2,
        OP_CANCEL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        EV_SEND    = 3'd0,
        EV_RESEND  = 3'd1,
        EV_TIMEOUT = 3'd2,
        EV_REPLY   = 3'd3,
        EV_FULL    = 3'd4
    } ev_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PING,
        ST_PING_SECOND,
        ST_REPLY,
        ST_TICK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        op_t                opcode;
        logic [31:0]        peer_addr;
        logic [15:0]        peer_port;
        logic signed [31:0] server_tag;
        logic [7:0]         cause_code;
        logic [7:0]         query_command;
    } req_t;

    typedef struct packed {
        ev_t                event_kind;
        logic [31:0]        out_addr;
        logic [15:0]        out_port;
        logic [7:0]         out_command;
        logic signed [31:0] out_tag;
        logic [7:0]         out_cause;
        logic [13:0]        round_trip_ms;
        logic               matched;
        logic               last_result;
    } rsp_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [1:0]  max_retries;
        logic [7:0]  auto_cause_code;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic is_status;
    } cls_t;

endpackage

### rtl/opt_front.sv
// Input queue that accepts and classifies request items
module opt_front
    import opt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_item,
    input  logic pop,
    output cls_t q_cls,
    output req_t q_item
);

    req_t q_mem [QUEUE_DEPTH];
    logic wp_reg;
    logic rp_reg;
    logic [1:0] cnt_reg;
    logic push;
    logic take;

    assign req_stall = (cnt_reg == 2'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign take      = pop && (cnt_reg != 2'd0);
    assign q_item    = q_mem[rp_reg];

    always_comb
    begin
        q_cls.valid     = (cnt_reg != 2'd0);
        q_cls.is_status = (q_item.query_command == CMD_STATUS);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= req_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (take)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(take);
        end
    end

endmodule

### rtl/opt_back.sv
// Table scan engine that executes items and produces result items
module opt_back
    import opt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cls_t q_cls,
    input  req_t q_item,
    output logic pop,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_item
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [31:0] addr_mem    [TABLE_DEPTH];
    logic [15:0] port_mem    [TABLE_DEPTH];
    logic [31:0] tag_mem     [TABLE_DEPTH];
    logic [7:0]  cause_mem   [TABLE_DEPTH];
    logic [7:0]  cmd_mem     [TABLE_DEPTH];
    logic [31:0] sent_mem    [TABLE_DEPTH];
    logic        replied_mem [TABLE_DEPTH];
    logic [1:0]  tries_mem   [TABLE_DEPTH];

    state_t      state_reg, state_next;
    req_t        work_reg;
    logic        work_status_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [4:0]  n_reg, n_next;
    logic [31:0] clock_reg, clock_next;
    logic        bc_have_reg, bc_have_next;
    logic [13:0] bc_rtt_reg, bc_rtt_next;
    logic        pend_valid_reg, pend_valid_next;
    rsp_t        pend_reg, pend_next;
    logic        out_valid_reg;
    rsp_t        out_reg;

    logic [IW-1:0] widx;
    logic [31:0] e_addr, e_sent, age;
    logic [15:0] e_port;
    logic [7:0]  e_cause, e_cmd;
    logic [31:0] e_tag;
    logic        e_replied;
    logic [1:0]  e_tries;
    logic [13:0] e_rtt;
    logic        at_end, key_hit, expired, is_full;
    logic        out_free, can_emit;

    logic        emit, finish, push;
    rsp_t        emit_item;
    rsp_t        push_item;
    logic        wr_new, wr_append, set_replied, retry_upd, rm_en;

    assign widx      = idx_reg[IW-1:0];
    assign e_addr    = addr_mem[widx];
    assign e_port    = port_mem[widx];
    assign e_tag     = tag_mem[widx];
    assign e_cause   = cause_mem[widx];
    assign e_cmd     = cmd_mem[widx];
    assign e_sent    = sent_mem[widx];
    assign e_replied = replied_mem[widx];
    assign e_tries   = tries_mem[widx];
    assign age       = clock_reg - e_sent;
    assign e_rtt     = (age > RTT_NONE_W) ? RTT_NONE : age[13:0];
    assign at_end    = (idx_reg >= count_reg);
    assign key_hit   = (e_addr == work_reg.peer_addr) && (e_port == work_reg.peer_port);
    assign expired   = age > {16'd0, cfg.timeout_ticks};
    assign is_full   = (count_reg == CW'(TABLE_DEPTH));
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign can_emit  = !pend_valid_reg || out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_cls.valid)
                begin
                    case (q_item.opcode)
                        OP_PING:  state_next = ST_PING;
                        OP_REPLY: state_next = ST_REPLY;
                        OP_TICK:  state_next = ST_TICK;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PING:
            begin
                if ((at_end || key_hit) && can_emit)
                begin
                    if (at_end && is_full)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = work_status_reg ? ST_PING_SECOND : ST_FLUSH;
                    end
                end
            end
            ST_PING_SECOND:
            begin
                if (can_emit)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_REPLY:
            begin
                if ((at_end || key_hit) && can_emit)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_TICK:
            begin
                if (at_end || n_reg == 5'(MAX_RESULTS))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        emit         = 1'b0;
        finish       = 1'b0;
        wr_new       = 1'b0;
        wr_append    = 1'b0;
        set_replied  = 1'b0;
        retry_upd    = 1'b0;
        rm_en        = 1'b0;
        count_next   = count_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        clock_next   = clock_reg;
        bc_have_next = bc_have_reg;
        bc_rtt_next  = bc_rtt_reg;
        emit_item.event_kind    = EV_SEND;
        emit_item.out_addr      = work_reg.peer_addr;
        emit_item.out_port      = work_reg.peer_port;
        emit_item.out_command   = work_reg.query_command;
        emit_item.out_tag       = work_reg.server_tag;
        emit_item.out_cause     = work_reg.cause_code;
        emit_item.round_trip_ms = 14'd0;
        emit_item.matched       = 1'b0;
        emit_item.last_result   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_cls.valid)
                begin
                    pop          = 1'b1;
                    idx_next     = '0;
                    n_next       = 5'd0;
                    bc_have_next = 1'b0;
                    if (q_item.opcode == OP_TICK)
                    begin
                        clock_next = clock_reg + 32'd1;
                    end
                    if (q_item.opcode == OP_CANCEL)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_PING:
            begin
                if (!at_end && !key_hit)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else if (can_emit)
                begin
                    emit = 1'b1;
                    if (at_end && is_full)
                    begin
                        emit_item.event_kind = EV_FULL;
                    end
                    else
                    begin
                        wr_new = 1'b1;
                        if (at_end)
                        begin
                            wr_append  = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            ST_PING_SECOND:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    emit_item.out_command = CMD_BASIC;
                end
            end
            ST_REPLY:
            begin
                emit_item.event_kind  = EV_REPLY;
                emit_item.out_command = CMD_BASIC;
                if (!at_end && !key_hit)
                begin
                    if (e_addr == BCAST_ADDR)
                    begin
                        bc_have_next = 1'b1;
                        bc_rtt_next  = e_rtt;
                    end
                    idx_next = idx_reg + CW'(1);
                end
                else if (can_emit)
                begin
                    emit = 1'b1;
                    if (!at_end)
                    begin
                        set_replied             = 1'b1;
                        emit_item.out_tag       = e_tag;
                        emit_item.out_cause     = e_cause;
                        emit_item.round_trip_ms = e_rtt;
                        emit_item.matched       = 1'b1;
                    end
                    else
                    begin
                        emit_item.out_tag       = -32'sd1;
                        emit_item.out_cause     = CAUSE_NONE;
                        emit_item.round_trip_ms = bc_have_reg ? bc_rtt_reg : RTT_NONE;
                    end
                end
            end
            ST_TICK:
            begin
                emit_item.out_addr  = e_addr;
                emit_item.out_port  = e_port;
                emit_item.out_tag   = e_tag;
                emit_item.out_cause = e_cause;
                if (!at_end && n_reg != 5'(MAX_RESULTS))
                begin
                    if (!expired)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                    else if (e_replied || e_addr == BCAST_ADDR)
                    begin
                        rm_en      = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                    else if (can_emit)
                    begin
                        emit   = 1'b1;
                        n_next = n_reg + 5'd1;
                        if (e_cause == cfg.auto_cause_code && e_tries < cfg.max_retries)
                        begin
                            retry_upd             = 1'b1;
                            emit_item.event_kind  = EV_RESEND;
                            emit_item.out_command = e_cmd;
                            idx_next              = idx_reg + CW'(1);
                        end
                        else
                        begin
                            emit_item.event_kind  = EV_TIMEOUT;
                            emit_item.out_command = CMD_BASIC;
                            rm_en                 = 1'b1;
                            count_next            = count_reg - CW'(1);
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                finish = 1'b1;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        push            = pend_valid_reg && (emit || (finish && out_free));
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (emit)
        begin
            pend_valid_next = 1'b1;
            pend_next       = emit_item;
        end
        else if (finish && out_free)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        push_item             = pend_reg;
        push_item.last_result = finish;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_cls.valid)
        begin
            work_reg        <= q_item;
            work_status_reg <= q_cls.is_status;
        end
        pend_reg <= pend_next;
        bc_rtt_reg <= bc_rtt_next;
        if (push)
        begin
            out_reg <= push_item;
        end
        if (wr_new)
        begin
            addr_mem[widx]  <= work_reg.peer_addr;
            port_mem[widx]  <= work_reg.peer_port;
            tag_mem[widx]   <= work_reg.server_tag;
            cause_mem[widx] <= work_reg.cause_code;
            cmd_mem[widx]   <= work_reg.query_command;
            sent_mem[widx]  <= clock_reg;
            tries_mem[widx] <= 2'd0;
            if (wr_append)
            begin
                replied_mem[widx] <= 1'b0;
            end
        end
        if (set_replied)
        begin
            replied_mem[widx] <= 1'b1;
        end
        if (retry_upd)
        begin
            tries_mem[widx] <= e_tries + 2'd1;
            sent_mem[widx]  <= clock_reg;
        end
        if (rm_en)
        begin
            for (int j = 0; j < TABLE_DEPTH - 1; j++)
            begin
                if (IW'(j) >= widx)
                begin
                    addr_mem[j]    <= addr_mem[j + 1];
                    port_mem[j]    <= port_mem[j + 1];
                    tag_mem[j]     <= tag_mem[j + 1];
                    cause_mem[j]   <= cause_mem[j + 1];
                    cmd_mem[j]     <= cmd_mem[j + 1];
                    sent_mem[j]    <= sent_mem[j + 1];
                    replied_mem[j] <= replied_mem[j + 1];
                    tries_mem[j]   <= tries_mem[j + 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= 5'd0;
            clock_reg      <= 32'd0;
            bc_have_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            clock_reg      <= clock_next;
            bc_have_reg    <= bc_have_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

`include "outstanding_ping_tracker_unit_macros.svh"

    `OPT_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_DEPTH))
    `OPT_ASSERT(a_idle_no_pend, state_reg == ST_IDLE |-> !pend_valid_reg)
    `OPT_ASSERT_ALWAYS(a_result_bound, n_reg <= 5'(MAX_RESULTS))
    `OPT_ASSERT(a_push_needs_room, push |-> out_free)

endmodule

### rtl/outstanding_ping_tracker_unit.sv
// Top level of the outstanding ping tracker
// Each item waits in a two-entry input queue, then the table engine walks the
// entry table one entry per clock through its single read port while no
// result is held up by a stalled output: a ping or a reply scans up to the
// match, a tick scans until the end or the result limit, and a cancel empties
// the table without a scan. Results leave through a one-item staging register
// and an output register, so a stalled output halts the scan only when both
// are full. The table powers up empty and needs no clearing pass.
module outstanding_ping_tracker_unit
    import opt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req_item,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    cls_t q_cls;
    req_t q_item;
    logic pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
            cfg_reg.max_retries     <= RETRIES_RST;
            cfg_reg.auto_cause_code <= AUTO_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMEOUT: cfg_reg.timeout_ticks   <= cfg_data;
                CFG_RETRIES: cfg_reg.max_retries     <= cfg_data[1:0];
                CFG_AUTO:    cfg_reg.auto_cause_code <= cfg_data[7:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    opt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .pop       (pop),
        .q_cls     (q_cls),
        .q_item    (q_item)
    );

    opt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_cls     (q_cls),
        .q_item    (q_item),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule
